>>> rtl/mp2d_pkg.sv
package mp2d_pkg;

    localparam int MAX_WINDOW  = 8;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int LINE_ROWS = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int BANK_W    = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;
    localparam int PHASE_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W     = 4;
    localparam int DIM_W     = 11;
    localparam int NUM_REGS  = 4;
    localparam int ADDR_W    = $clog2(4 * NUM_REGS);
    localparam int DATA_W    = 32;

    typedef enum logic [1:0] {
        REG_WINDOW,
        REG_STEP,
        REG_WIDTH,
        REG_HEIGHT
    } reg_idx_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic              valid;
        logic [COL_W-1:0]  col;
        logic [BANK_W-1:0] bank;
        logic [WIN_W-1:0]  win;
        logic              active;
        logic              emit;
        logic              row_end;
        logic              plane_end;
        sample_t           sample;
    } line_req_t;

    typedef struct packed {
        logic    valid;
        logic    active;
        logic    emit;
        logic    row_end;
        logic    plane_end;
        sample_t col_max;
    } line_res_t;

    function automatic sample_t smax(sample_t a, sample_t b);
        return ($signed(b) > $signed(a)) ? b : a;
    endfunction

endpackage

>>> rtl/max_pool_2d_stream_unit.sv
// Channel   Signals                                   Item
// input     sample_valid / sample_ready               sample
// output    result_valid / result_ready               pooled_max, row_end, plane_end
// config    psel penable pwrite paddr pwdata prdata   4 registers at 4*i, pready tied high
//
// One sample per cycle sustained; the line store is one 1024 x 112 memory, read and
// written back once per item, with forwarding for back-to-back items on one column.
// Accept to result valid: memory read on the accept edge, column max, window max
// into queue, each registered in turn.
// A 4-entry output queue takes up stalls; sample_ready drops when it and the two
// stages in flight could fill it. No clearing pass after reset.
module max_pool_2d_stream_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mp2d_pkg::ADDR_W-1:0]    paddr,
    input  logic [mp2d_pkg::DATA_W-1:0]    pwdata,
    output logic [mp2d_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  mp2d_pkg::sample_t              sample,
    output logic                           result_valid,
    input  logic                           result_ready,
    output mp2d_pkg::sample_t              pooled_max,
    output logic                           row_end,
    output logic                           plane_end
);
    import mp2d_pkg::*;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        sample_t pooled_max;
        logic    row_end;
        logic    plane_end;
    } out_item_t;

    logic [WIN_W-1:0]   window_size_reg;
    logic [WIN_W-1:0]   step_size_reg;
    logic [DIM_W-1:0]   plane_width_reg;
    logic [DIM_W-1:0]   plane_height_reg;

    logic [WIN_W-1:0]   win_eff;
    logic [WIN_W-1:0]   step_eff;
    logic [DIM_W-1:0]   width_eff;
    logic [DIM_W-1:0]   height_eff;

    logic [COL_W-1:0]   col_pos_reg, col_pos_next;
    logic [ROW_W-1:0]   row_pos_reg, row_pos_next;
    logic [PHASE_W-1:0] col_phase_reg, col_phase_next;
    logic [PHASE_W-1:0] row_phase_reg, row_phase_next;
    logic [BANK_W-1:0]  bank_reg, bank_next;

    logic               cfg_write;
    reg_idx_t           cfg_idx;
    logic               sample_fire;
    logic               s1_busy_reg;
    logic [DIM_W-1:0]   col_inc;
    logic [DIM_W-1:0]   row_inc;

    line_req_t          req;
    line_res_t          res;

    sample_t            colwin_reg [LINE_ROWS];
    sample_t            win_max;

    out_item_t          fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   fifo_count_reg;
    logic [CNT_W-1:0]   credit;
    logic               push;
    logic               pop;
    out_item_t          head;

    function automatic logic [PHASE_W-1:0] next_phase(logic [PHASE_W-1:0] ph,
                                                      logic [WIN_W-1:0] st);
        logic [WIN_W-1:0] inc;
        inc = WIN_W'(ph) + WIN_W'(1);
        return (inc >= st) ? '0 : PHASE_W'(inc);
    endfunction

    // configuration
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready    = 1'b1;

    always_comb
    begin
        unique case (cfg_idx)
            REG_WINDOW: prdata = DATA_W'(window_size_reg);
            REG_STEP:   prdata = DATA_W'(step_size_reg);
            REG_WIDTH:  prdata = DATA_W'(plane_width_reg);
            REG_HEIGHT: prdata = DATA_W'(plane_height_reg);
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (int'(window_size_reg) > MAX_WINDOW)
        begin
            win_eff = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = window_size_reg;
        end

        if (step_size_reg == '0)
        begin
            step_eff = win_eff;
        end
        else if (int'(step_size_reg) > MAX_WINDOW)
        begin
            step_eff = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            step_eff = step_size_reg;
        end

        if (plane_width_reg == '0)
        begin
            width_eff = DIM_W'(1);
        end
        else if (int'(plane_width_reg) > MAX_WIDTH)
        begin
            width_eff = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = plane_width_reg;
        end

        if (plane_height_reg == '0)
        begin
            height_eff = DIM_W'(1);
        end
        else if (int'(plane_height_reg) > MAX_HEIGHT)
        begin
            height_eff = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = plane_height_reg;
        end
    end

    // position tracking and request build
    assign sample_fire = sample_valid && sample_ready;
    assign col_inc     = DIM_W'(col_pos_reg) + DIM_W'(1);
    assign row_inc     = DIM_W'(row_pos_reg) + DIM_W'(1);

    always_comb
    begin
        req.valid     = sample_fire;
        req.col       = col_pos_reg;
        req.bank      = bank_reg;
        req.win       = win_eff;
        req.sample    = sample;
        req.active    = row_inc >= DIM_W'(win_eff);
        req.emit      = req.active && (row_phase_reg == '0) &&
                        (col_inc >= DIM_W'(win_eff)) && (col_phase_reg == '0);
        req.row_end   = (DIM_W'(col_pos_reg) + DIM_W'(step_eff)) >= width_eff;
        req.plane_end = req.row_end &&
                        ((DIM_W'(row_pos_reg) + DIM_W'(step_eff)) >= height_eff);
    end

    always_comb
    begin
        col_pos_next   = col_pos_reg;
        row_pos_next   = row_pos_reg;
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        bank_next      = bank_reg;
        priority if (cfg_write)
        begin
            col_pos_next   = '0;
            row_pos_next   = '0;
            col_phase_next = '0;
            row_phase_next = '0;
            bank_next      = '0;
        end
        else if (sample_fire)
        begin
            if (col_inc >= width_eff)
            begin
                col_pos_next   = '0;
                col_phase_next = '0;
                if (row_inc >= height_eff)
                begin
                    row_pos_next   = '0;
                    row_phase_next = '0;
                    bank_next      = '0;
                end
                else
                begin
                    row_pos_next = row_inc[ROW_W-1:0];
                    if (int'(bank_reg) == LINE_ROWS - 1)
                    begin
                        bank_next = '0;
                    end
                    else
                    begin
                        bank_next = bank_reg + BANK_W'(1);
                    end
                    if (row_inc >= DIM_W'(win_eff))
                    begin
                        row_phase_next = next_phase(row_phase_reg, step_eff);
                    end
                    else
                    begin
                        row_phase_next = '0;
                    end
                end
            end
            else
            begin
                col_pos_next = col_inc[COL_W-1:0];
                if (col_inc >= DIM_W'(win_eff))
                begin
                    col_phase_next = next_phase(col_phase_reg, step_eff);
                end
                else
                begin
                    col_phase_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg  <= WIN_W'(2);
            step_size_reg    <= '0;
            plane_width_reg  <= DIM_W'(1024);
            plane_height_reg <= DIM_W'(1024);
            col_pos_reg      <= '0;
            row_pos_reg      <= '0;
            col_phase_reg    <= '0;
            row_phase_reg    <= '0;
            bank_reg         <= '0;
            s1_busy_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_idx)
                    REG_WINDOW: window_size_reg  <= pwdata[WIN_W-1:0];
                    REG_STEP:   step_size_reg    <= pwdata[WIN_W-1:0];
                    REG_WIDTH:  plane_width_reg  <= pwdata[DIM_W-1:0];
                    REG_HEIGHT: plane_height_reg <= pwdata[DIM_W-1:0];
                    default:    plane_height_reg <= plane_height_reg;
                endcase
            end
            col_pos_reg   <= col_pos_next;
            row_pos_reg   <= row_pos_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
            bank_reg      <= bank_next;
            s1_busy_reg   <= sample_fire;
        end
    end

    mp2d_line_unit u_line (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res)
    );

    // column-max window and window maximum
    always_comb
    begin
        win_max = res.col_max;
        for (int i = 0; i < LINE_ROWS; i++)
        begin
            if (i + 1 < int'(win_eff))
            begin
                win_max = smax(win_max, colwin_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res.active)
        begin
            colwin_reg[0] <= res.col_max;
            for (int i = 1; i < LINE_ROWS; i++)
            begin
                colwin_reg[i] <= colwin_reg[i-1];
            end
        end
    end

    // output queue
    assign push   = res.valid && res.emit;
    assign pop    = result_valid && result_ready;
    assign credit = fifo_count_reg + CNT_W'(s1_busy_reg) + CNT_W'(res.valid);
    assign sample_ready = credit < CNT_W'(FIFO_DEPTH);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= '{pooled_max: win_max,
                                      row_end:    res.row_end,
                                      plane_end:  res.plane_end};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                fifo_count_reg <= fifo_count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                fifo_count_reg <= fifo_count_reg - CNT_W'(1);
            end
        end
    end

    assign head         = fifo_mem[rd_ptr_reg];
    assign result_valid = fifo_count_reg != '0;
    assign pooled_max   = head.pooled_max;
    assign row_end      = head.row_end;
    assign plane_end    = head.plane_end;

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_col_in_plane: assert property (@(posedge clk) disable iff (!rst_n)
        DIM_W'(col_pos_reg) < width_eff)
        else $error("column position beyond plane width");

    a_plane_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && plane_end) |-> row_end)
        else $error("plane end without row end");

endmodule

>>> rtl/mp2d_line_unit.sv
module mp2d_line_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  mp2d_pkg::line_req_t req,
    output mp2d_pkg::line_res_t res
);
    import mp2d_pkg::*;

    typedef sample_t [LINE_ROWS-1:0] line_word_t;

    // one entry per column, one slot per buffered row
    line_word_t line_mem [MAX_WIDTH];

    line_word_t        rd_word_reg;
    line_word_t        fwd_word_reg;
    line_word_t        cur_word;
    line_word_t        wr_word;
    line_req_t         s1_reg;
    logic              fwd_valid_reg;
    logic [COL_W-1:0]  fwd_col_reg;
    line_res_t         res_reg;
    line_res_t         res_next;
    logic [LINE_ROWS-1:0] use_slot;
    logic [BANK_W:0]   age;
    sample_t           col_max;

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            rd_word_reg <= line_mem[req.col];
        end
        if (s1_reg.valid)
        begin
            line_mem[s1_reg.col] <= wr_word;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_col_reg  <= s1_reg.col;
        fwd_word_reg <= wr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            fwd_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            s1_reg        <= req;
            fwd_valid_reg <= s1_reg.valid;
            res_reg       <= res_next;
        end
    end

    // write-back of the previous item lands on the edge this read was taken
    always_comb
    begin
        if (fwd_valid_reg && (fwd_col_reg == s1_reg.col))
        begin
            cur_word = fwd_word_reg;
        end
        else
        begin
            cur_word = rd_word_reg;
        end
        wr_word = cur_word;
        wr_word[s1_reg.bank] = s1_reg.sample;
    end

    // slot j holds row r-d for d = (bank - j) mod rows > 0; d == 0 holds row r-rows, the oldest
    always_comb
    begin
        use_slot = '0;
        age      = '0;
        for (int j = 0; j < LINE_ROWS; j++)
        begin
            if (s1_reg.bank >= BANK_W'(j))
            begin
                age = (BANK_W+1)'(s1_reg.bank) - (BANK_W+1)'(j);
            end
            else
            begin
                age = (BANK_W+1)'(s1_reg.bank) + (BANK_W+1)'(LINE_ROWS) - (BANK_W+1)'(j);
            end
            if (age == '0)
            begin
                use_slot[j] = int'(s1_reg.win) > LINE_ROWS;
            end
            else
            begin
                use_slot[j] = int'(age) < int'(s1_reg.win);
            end
        end
    end

    always_comb
    begin
        col_max = s1_reg.sample;
        for (int j = 0; j < LINE_ROWS; j++)
        begin
            if (use_slot[j])
            begin
                col_max = smax(col_max, cur_word[j]);
            end
        end
        res_next.valid     = s1_reg.valid;
        res_next.active    = s1_reg.active;
        res_next.emit      = s1_reg.emit;
        res_next.row_end   = s1_reg.row_end;
        res_next.plane_end = s1_reg.plane_end;
        res_next.col_max   = col_max;
    end

    assign res = res_reg;

    a_res_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> ##2 res.valid)
        else $error("column result missing two cycles after request");

    a_res_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> $past(req.valid, 2))
        else $error("column result without request");

    a_emit_active: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.emit) |-> res.active)
        else $error("window closed on an inactive row");

endmodule

>>> dv/max_pool_2d_stream_unit_tb.sv
module max_pool_2d_stream_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mp2d_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_CYCLES  = 250;
    localparam int SETTLE       = 16;

    typedef struct {
        sample_t pooled_max;
        logic    row_end;
        logic    plane_end;
    } window_result_t;

    typedef sample_t sample_list_t [$];

    class pool_tracker;
        logic [WIN_W-1:0] window_reg;
        logic [WIN_W-1:0] step_reg;
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        sample_t          line_mem [LINE_ROWS*MAX_WIDTH];
        sample_t          col_max [MAX_WINDOW];
        int unsigned      col_pos;
        int unsigned      row_pos;
        int unsigned      col_ph;
        int unsigned      row_ph;
        window_result_t   expected [$];
        int               mismatches;

        function new();
            window_reg = 2;
            step_reg   = 0;
            width_reg  = 1024;
            height_reg = 1024;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            col_pos = 0;
            row_pos = 0;
            col_ph  = 0;
            row_ph  = 0;
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned next_ph(int unsigned p, int unsigned s);
            return (p + 1 >= s) ? 0 : p + 1;
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function logic [DATA_W-1:0] reg_value(reg_idx_t idx);
            case (idx)
                REG_WINDOW: return DATA_W'(window_reg);
                REG_STEP:   return DATA_W'(step_reg);
                REG_WIDTH:  return DATA_W'(width_reg);
                default:    return DATA_W'(height_reg);
            endcase
        endfunction

        function void set_register(reg_idx_t idx, logic [DATA_W-1:0] v);
            case (idx)
                REG_WINDOW: window_reg = v[WIN_W-1:0];
                REG_STEP:   step_reg   = v[WIN_W-1:0];
                REG_WIDTH:  width_reg  = v[DIM_W-1:0];
                default:    height_reg = v[DIM_W-1:0];
            endcase
            restart();
        endfunction

        function void check_register(reg_idx_t idx, logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            want = reg_value(idx);
            if (got !== want)
                note_mismatch($sformatf("register %s read back: expected %0h, got %0h",
                                        idx.name(), want, got));
        endfunction

        function void take_sample(sample_t x);
            int unsigned    k;
            int unsigned    s;
            int unsigned    w;
            int unsigned    h;
            int unsigned    c;
            int unsigned    r;
            int unsigned    i;
            int unsigned    bank;
            sample_t        colmax;
            sample_t        m;
            window_result_t res;
            k = clamp(window_reg, 1, MAX_WINDOW);
            s = (step_reg == 0) ? k : clamp(step_reg, 1, MAX_WINDOW);
            w = clamp(width_reg, 1, MAX_WIDTH);
            h = clamp(height_reg, 1, MAX_HEIGHT);
            c = col_pos;
            r = row_pos;
            if (c >= w) c = 0;
            if (r >= h) r = 0;

            if (r + 1 >= k) begin
                colmax = x;
                for (i = 1; i < k; i++) begin
                    bank = (r - i) % LINE_ROWS;
                    if (line_mem[bank*MAX_WIDTH + c] > colmax)
                        colmax = line_mem[bank*MAX_WIDTH + c];
                end
                for (i = MAX_WINDOW - 1; i > 0; i--)
                    col_max[i] = col_max[i-1];
                col_max[0] = colmax;
            end

            line_mem[(r % LINE_ROWS)*MAX_WIDTH + c] = x;

            if (r + 1 >= k && row_ph == 0 && c + 1 >= k && col_ph == 0) begin
                m = col_max[0];
                for (i = 1; i < k; i++)
                    if (col_max[i] > m) m = col_max[i];
                res.pooled_max = m;
                res.row_end    = (c + s >= w);
                res.plane_end  = res.row_end && (r + s >= h);
                expected.push_back(res);
            end

            c++;
            if (c >= w) begin
                c = 0;
                col_ph = 0;
                r++;
                if (r >= h) begin
                    r = 0;
                    row_ph = 0;
                end else if (r >= k) begin
                    row_ph = next_ph(row_ph, s);
                end else begin
                    row_ph = 0;
                end
            end else if (c >= k) begin
                col_ph = next_ph(col_ph, s);
            end else begin
                col_ph = 0;
            end
            col_pos = c;
            row_pos = r;
        endfunction

        function void match_result(sample_t pm, logic re, logic pe);
            window_result_t want;
            if (expected.size() == 0) begin
                note_mismatch($sformatf("unexpected result: max %0d row_end %0b plane_end %0b",
                                        pm, re, pe));
                return;
            end
            want = expected.pop_front();
            if (pm !== want.pooled_max || re !== want.row_end || pe !== want.plane_end)
                note_mismatch($sformatf({"result mismatch: expected max %0d row_end %0b ",
                                         "plane_end %0b, got max %0d row_end %0b plane_end %0b"},
                                        want.pooled_max, want.row_end, want.plane_end,
                                        pm, re, pe));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              sample_valid = 1'b0;
    logic              sample_ready;
    sample_t           sample = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    sample_t           pooled_max;
    logic              row_end;
    logic              plane_end;

    pool_tracker tracker;
    bit          steady = 1'b0;
    bit          hold_request = 1'b0;
    int          sent_items = 0;

    max_pool_2d_stream_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .pooled_max   (pooled_max),
        .row_end      (row_end),
        .plane_end    (plane_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
                tracker.take_sample(sample);
            if (result_valid && result_ready)
                tracker.match_result(pooled_max, row_end, plane_end);
        end
    end

    // output side back-pressure
    initial
    begin
        int pick;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (steady)
            begin
                result_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    result_ready <= 1'b1;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
                else if (pick < 94)
                begin
                    result_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    result_ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                end
            end
        end
    end

    function automatic int gap_len();
        int pick;
        if (steady) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 70) return 0;
        if (pick < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic sample_t pick_sample(int mode);
        case (mode)
            1: return sample_t'(int'($urandom_range(0, 8)) - 4);
            2:
            begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return 16'shffff;
                    3:       return 16'sh0000;
                    default: return sample_t'($urandom);
                endcase
            end
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic sample_list_t make_items(int unsigned n, int mode);
        sample_list_t q;
        for (int unsigned i = 0; i < n; i++)
            q.push_back(pick_sample(mode));
        return q;
    endfunction

    task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.set_register(idx, value);
    endtask

    task automatic apb_read_check(reg_idx_t idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(4 * int'(idx));
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.check_register(idx, prdata);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (tracker.expected.size() != 0);
    endtask

    task automatic wait_quiet();
        wait_drained();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_config(int unsigned win, int unsigned step,
                               int unsigned width, int unsigned height);
        logic [DATA_W-1:0] vals [NUM_REGS];
        logic [DATA_W-1:0] junk;
        int unsigned       first;
        reg_idx_t          idx;
        vals[0] = win;
        vals[1] = step;
        vals[2] = width;
        vals[3] = height;
        first = $urandom_range(0, NUM_REGS - 1);
        for (int j = 0; j < NUM_REGS; j++)
        begin
            idx = reg_idx_t'((first + j) % NUM_REGS);
            // unused upper bits must be ignored
            junk = '0;
            if ($urandom_range(0, 3) == 0)
                junk = $urandom << ((int'(idx) < 2) ? WIN_W : DIM_W);
            apb_write(idx, vals[int'(idx)] | junk);
            apb_read_check(idx);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(sample_t x, int gap);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= x;
        do @(posedge clk); while (!sample_ready);
    endtask

    task automatic run_phase(int unsigned win, int unsigned step, int unsigned width,
                             int unsigned height, sample_list_t items, int pause_at,
                             bit stall_out);
        wait_quiet();
        load_config(win, step, width, height);
        if (stall_out)
            hold_request = 1'b1;
        for (int i = 0; i < items.size(); i++)
        begin
            send_sample(items[i], gap_len());
            sent_items++;
            if (i == pause_at && i < items.size() - 1)
            begin
                sample_valid <= 1'b0;
                wait_drained();
            end
        end
        sample_valid <= 1'b0;
    endtask

    initial
    begin
        sample_list_t seq;
        int unsigned  win;
        int unsigned  step;
        int unsigned  width;
        int unsigned  height;
        int unsigned  k_e;
        int unsigned  w_e;
        int unsigned  h_e;
        int unsigned  n;
        int unsigned  pick;
        int           pause_at;

        tracker = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pass-through window: extremes of the sample field
        seq = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff,
                16'sh0001, 16'sh5555, 16'shaaaa, 16'sh7ffe};
        run_phase(1, 0, 4, 2, seq, -1, 1'b0);
        // overlapping 2x2 windows, negatives and ties
        seq = '{16'sh8000, 16'shffff, 16'sh7fff, 16'sh8000, 16'sh0000,
                16'sh8001, 16'sh0005, 16'shfffb, 16'sh7fff};
        run_phase(2, 1, 3, 3, seq, -1, 1'b0);

        run_phase(0, 3, 7, 4, make_items(56, 0), -1, 1'b0);
        run_phase(15, 0, 10, 9, make_items(180, 2), -1, 1'b0);
        run_phase(3, 11, 12, 7, make_items(84, 0), 30, 1'b0);
        run_phase(1, 0, 0, 5, make_items(10, 2), -1, 1'b0);
        run_phase(1, 0, 6, 0, make_items(12, 1), -1, 1'b0);
        run_phase(5, 0, 4, 6, make_items(48, 0), -1, 1'b0);
        run_phase(8, 1, 8, 8, make_items(64, 1), -1, 1'b0);
        run_phase(1, 8, 2047, 1, make_items(64, 0), -1, 1'b0);
        run_phase(1, 8, 1, 2047, make_items(64, 0), -1, 1'b0);

        // long output stall with the input kept busy, then a full drain midway
        steady = 1'b1;
        run_phase(1, 0, 8, 8, make_items(64, 0), 40, 1'b1);
        steady = 1'b0;

        while (sent_items < 1550)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 2)       win = 0;
            else if (pick < 4)  win = $urandom_range(9, 15);
            else if (pick < 14) win = $urandom_range(1, 3);
            else                win = $urandom_range(4, 8);
            k_e = (win == 0) ? 1 : (win > MAX_WINDOW) ? MAX_WINDOW : win;

            pick = $urandom_range(0, 9);
            if (pick < 3)      step = 0;
            else if (pick < 8) step = $urandom_range(1, k_e);
            else if (pick < 9) step = $urandom_range(k_e, MAX_WINDOW);
            else               step = $urandom_range(9, 15);

            if ($urandom_range(0, 19) == 0)      width = 0;
            else if ($urandom_range(0, 9) == 0)  width = $urandom_range(25, 64);
            else                                 width = $urandom_range(1, 24);

            if ($urandom_range(0, 19) == 0)      height = 0;
            else if ($urandom_range(0, 19) == 0) height = $urandom_range(13, 40);
            else                                 height = $urandom_range(1, 12);

            w_e = (width == 0) ? 1 : width;
            h_e = (height == 0) ? 1 : height;
            n = w_e * h_e * $urandom_range(1, 2);
            // a partial plane leaves the next write to restart mid-plane
            if ($urandom_range(0, 3) == 0)
                n += $urandom_range(0, w_e * h_e - 1);
            if (n > 300)
                n = 300;
            pause_at = -1;
            if (n >= 2 && $urandom_range(0, 3) == 0)
                pause_at = $urandom_range(0, n - 2);
            steady = ($urandom_range(0, 6) == 0);
            run_phase(win, step, width, height, make_items(n, $urandom_range(0, 2)),
                      pause_at, 1'b0);
            steady = 1'b0;
        end

        wait_quiet();
        if (tracker.mismatches == 0 && tracker.expected.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
